### rtl/rrq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the round-robin ready queue
// no dependencies

package rrq_pkg;

  localparam int IdW             = 6;
  localparam int SliceW          = 8;
  localparam int CountW          = 8;
  localparam int NumTasksDefault = 64;
  localparam int PaddrW          = 3;
  localparam int PdataW          = 32;

  localparam logic [SliceW-1:0] IdleSliceReset = SliceW'(1);
  localparam logic [CountW-1:0] CountMax       = '1;

  typedef enum logic [1:0] {
    CmdEnqueue = 2'd0,
    CmdDequeue = 2'd1,
    CmdPick    = 2'd2,
    CmdTick    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrQueued   = 2'd1,
    ErrIdle     = 2'd2,
    ErrUnqueued = 2'd3
  } err_e;

  typedef enum logic [0:0] {
    CfgIdleTaskId = 1'b0,
    CfgIdleSlice  = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    StIdle = 1'b0,
    StExec = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IdW-1:0]    task_id;
    logic [SliceW-1:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0]    picked_task;
    logic              picked_idle;
    logic              slice_expired;
    logic [CountW-1:0] running_count;
    err_e              error_code;
  } out_t;

  typedef struct packed {
    logic              queued;
    logic [SliceW-1:0] slice;
  } stat_t;

  typedef struct packed {
    logic           next_we;
    logic [IdW-1:0] next_wdata;
    logic           prev_we;
    logic [IdW-1:0] prev_wdata;
    logic           stat_we;
    stat_t          stat_wdata;
  } mem_wr_t;

  typedef struct packed {
    logic [IdW-1:0] next_id;
    logic [IdW-1:0] prev_id;
    stat_t          stat;
  } mem_rd_t;

endpackage

### rtl/rrq_store.sv
`timescale 1ns / 1ps
// link and status memories of the ready queue, with the status clearing sweep
// depends on rrq_pkg

module rrq_store #(
  parameter int NUM_TASKS = rrq_pkg::NumTasksDefault,
  localparam int IdxW = $clog2(NUM_TASKS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output rrq_pkg::mem_rd_t rd_data_o,
  input  rrq_pkg::mem_wr_t wr_i,
  input  logic [IdxW-1:0]  next_waddr_i,
  input  logic [IdxW-1:0]  prev_waddr_i,
  input  logic [IdxW-1:0]  stat_waddr_i,
  output logic             clr_busy_o
);

  logic [rrq_pkg::IdW-1:0] next_mem [NUM_TASKS];
  logic [rrq_pkg::IdW-1:0] prev_mem [NUM_TASKS];
  rrq_pkg::stat_t          stat_mem [NUM_TASKS];

  rrq_pkg::mem_rd_t rd_data_q;
  logic [IdxW:0]    clr_cnt_q, clr_cnt_d;
  logic             clr_busy;
  logic             stat_we;
  logic [IdxW-1:0]  stat_waddr;
  rrq_pkg::stat_t   stat_wdata;

  assign clr_busy = clr_cnt_q != (IdxW+1)'(NUM_TASKS);
  assign clr_cnt_d = clr_busy ? clr_cnt_q + (IdxW+1)'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // sweep clears queued flags and slices after reset
  always_comb begin
    if (clr_busy) begin
      stat_we    = 1'b1;
      stat_waddr = clr_cnt_q[IdxW-1:0];
      stat_wdata = '0;
    end else begin
      stat_we    = wr_i.stat_we;
      stat_waddr = stat_waddr_i;
      stat_wdata = wr_i.stat_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.next_we) begin
      next_mem[next_waddr_i] <= wr_i.next_wdata;
    end
    if (wr_i.prev_we) begin
      prev_mem[prev_waddr_i] <= wr_i.prev_wdata;
    end
    if (stat_we) begin
      stat_mem[stat_waddr] <= stat_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q.next_id <= next_mem[rd_addr_i];
      rd_data_q.prev_id <= prev_mem[rd_addr_i];
      rd_data_q.stat    <= stat_mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy;

endmodule

### rtl/rrq_ctrl.sv
`timescale 1ns / 1ps
// command sequencer: head, tail and count registers, list update and result register
// depends on rrq_pkg

module rrq_ctrl #(
  parameter int NUM_TASKS = rrq_pkg::NumTasksDefault,
  localparam int IdxW = $clog2(NUM_TASKS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rrq_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rrq_pkg::out_t                out_data_o,
  input  logic [rrq_pkg::IdW-1:0]      idle_task_id_i,
  input  logic [rrq_pkg::SliceW-1:0]   idle_slice_i,
  input  logic                         clr_busy_i,
  output logic                         rd_en_o,
  output logic [IdxW-1:0]              rd_addr_o,
  input  rrq_pkg::mem_rd_t             rd_data_i,
  output rrq_pkg::mem_wr_t             wr_o,
  output logic [IdxW-1:0]              next_waddr_o,
  output logic [IdxW-1:0]              prev_waddr_o,
  output logic [IdxW-1:0]              stat_waddr_o
);

  rrq_pkg::state_e state_q, state_d;
  logic [rrq_pkg::IdW-1:0]    head_q, head_d;
  logic [rrq_pkg::IdW-1:0]    tail_q, tail_d;
  logic                       nonempty_q, nonempty_d;
  logic [rrq_pkg::CountW-1:0] count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  rrq_pkg::out_t              out_data_q, out_data_d;

  rrq_pkg::cmd_e              cmd_q;
  logic [rrq_pkg::IdW-1:0]    tid_q;
  logic [rrq_pkg::SliceW-1:0] prio_q;
  logic                       tid_ok_q;

  logic                    in_ready, accept, exec_fire, unlink, idle_ok;
  logic [rrq_pkg::IdW-1:0] ut;
  rrq_pkg::mem_rd_t        rd;

  assign rd        = rd_data_i;
  assign in_ready  = (state_q == rrq_pkg::StIdle) && !clr_busy_i;
  assign accept    = in_valid_i && in_ready;
  assign exec_fire = (state_q == rrq_pkg::StExec) && (!out_valid_q || out_ready_i);
  assign idle_ok   = 32'(idle_task_id_i) < 32'(NUM_TASKS);
  assign ut        = (cmd_q == rrq_pkg::CmdPick) ? head_q : tid_q;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    nonempty_d   = nonempty_q;
    count_d      = count_q;
    out_data_d   = out_data_q;
    unlink       = 1'b0;
    wr_o         = '0;
    next_waddr_o = '0;
    prev_waddr_o = '0;
    stat_waddr_o = '0;
    rd_en_o      = 1'b0;
    if (in_data_i.cmd == rrq_pkg::CmdPick) begin
      rd_addr_o = nonempty_q ? IdxW'(head_q) : IdxW'(idle_task_id_i);
    end else begin
      rd_addr_o = IdxW'(in_data_i.task_id);
    end

    unique case (state_q)
      rrq_pkg::StIdle: begin
        if (accept) begin
          rd_en_o = 1'b1;
          state_d = rrq_pkg::StExec;
        end
      end
      rrq_pkg::StExec: begin
        if (exec_fire) begin
          state_d    = rrq_pkg::StIdle;
          out_data_d = '0;
          unique case (cmd_q)
            rrq_pkg::CmdEnqueue: begin
              if (tid_ok_q) begin
                if (rd.stat.queued) begin
                  out_data_d.error_code = rrq_pkg::ErrQueued;
                end else if (tid_q == idle_task_id_i) begin
                  out_data_d.error_code = rrq_pkg::ErrIdle;
                end else begin
                  if (nonempty_q) begin
                    wr_o.next_we    = 1'b1;
                    wr_o.next_wdata = tid_q;
                    next_waddr_o    = IdxW'(tail_q);
                    wr_o.prev_we    = 1'b1;
                    wr_o.prev_wdata = tail_q;
                    prev_waddr_o    = IdxW'(tid_q);
                    tail_d          = tid_q;
                  end else begin
                    head_d     = tid_q;
                    tail_d     = tid_q;
                    nonempty_d = 1'b1;
                  end
                  wr_o.stat_we           = 1'b1;
                  wr_o.stat_wdata.queued = 1'b1;
                  wr_o.stat_wdata.slice  = (rd.stat.slice == '0) ? prio_q : rd.stat.slice;
                  stat_waddr_o           = IdxW'(tid_q);
                  if (count_q != rrq_pkg::CountMax) begin
                    count_d = count_q + rrq_pkg::CountW'(1);
                  end
                end
              end
            end
            rrq_pkg::CmdDequeue: begin
              if (tid_ok_q) begin
                if (!rd.stat.queued) begin
                  out_data_d.error_code = rrq_pkg::ErrUnqueued;
                end else begin
                  unlink = 1'b1;
                  if (count_q != '0) begin
                    count_d = count_q - rrq_pkg::CountW'(1);
                  end
                end
              end
            end
            rrq_pkg::CmdPick: begin
              if (nonempty_q) begin
                out_data_d.picked_task = head_q;
                unlink                 = 1'b1;
              end else begin
                out_data_d.picked_task = idle_task_id_i;
                out_data_d.picked_idle = 1'b1;
                if (idle_ok) begin
                  wr_o.stat_we           = 1'b1;
                  wr_o.stat_wdata.queued = 1'b0;
                  wr_o.stat_wdata.slice  = idle_slice_i;
                  stat_waddr_o           = IdxW'(idle_task_id_i);
                end
              end
            end
            rrq_pkg::CmdTick: begin
              if (tid_ok_q) begin
                if (rd.stat.slice != '0) begin
                  wr_o.stat_we           = 1'b1;
                  wr_o.stat_wdata.queued = rd.stat.queued;
                  wr_o.stat_wdata.slice  = rd.stat.slice - rrq_pkg::SliceW'(1);
                  stat_waddr_o           = IdxW'(tid_q);
                end else begin
                  out_data_d.slice_expired = 1'b1;
                end
              end
            end
            default: ;
          endcase

          // remove ut from the list using the links read for it
          if (unlink) begin
            wr_o.stat_we           = 1'b1;
            wr_o.stat_wdata.queued = 1'b0;
            wr_o.stat_wdata.slice  = rd.stat.slice;
            stat_waddr_o           = IdxW'(ut);
            if (ut == head_q && ut == tail_q) begin
              nonempty_d = 1'b0;
            end else if (ut == head_q) begin
              head_d = rd.next_id;
            end else if (ut == tail_q) begin
              tail_d = rd.prev_id;
            end else begin
              wr_o.next_we    = 1'b1;
              wr_o.next_wdata = rd.next_id;
              next_waddr_o    = IdxW'(rd.prev_id);
              wr_o.prev_we    = 1'b1;
              wr_o.prev_wdata = rd.prev_id;
              prev_waddr_o    = IdxW'(rd.next_id);
            end
          end
          out_data_d.running_count = count_d;
        end
      end
      default: state_d = rrq_pkg::StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrq_pkg::StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      nonempty_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      nonempty_q  <= nonempty_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      cmd_q    <= in_data_i.cmd;
      tid_q    <= in_data_i.task_id;
      prio_q   <= in_data_i.priority_req;
      tid_ok_q <= 32'(in_data_i.task_id) < 32'(NUM_TASKS);
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/round_robin_ready_queue_core.sv
`timescale 1ns / 1ps
// Round-robin ready queue: task ids are kept as a doubly linked FIFO in next/prev link
// memories, with a queued flag and time slice per task in a status memory. StIdle takes
// a command and reads the memories at the addressed task (the head for a pick, or the idle
// task if the queue is empty); StExec waits for a free result register, then updates the
// links, status, head, tail and count and registers the result. No new command is taken
// until the last is through, and the single memory read port is used once per command.
// After reset the status memory is swept clear with in_ready_o low; register writes on the
// configuration port are taken at any time. Depends on rrq_pkg, rrq_ctrl and rrq_store.

module round_robin_ready_queue_core #(
  parameter int NUM_TASKS = rrq_pkg::NumTasksDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rrq_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rrq_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrq_pkg::PaddrW-1:0]  paddr,
  input  logic [rrq_pkg::PdataW-1:0]  pwdata,
  output logic [rrq_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);

  localparam int IdxW = $clog2(NUM_TASKS);

  logic [rrq_pkg::IdW-1:0]    idle_task_id_q, idle_task_id_d;
  logic [rrq_pkg::SliceW-1:0] idle_slice_q, idle_slice_d;
  rrq_pkg::cfg_reg_e          reg_sel;
  logic                       wr_fire;

  rrq_pkg::mem_rd_t rd_data;
  rrq_pkg::mem_wr_t wr;
  logic             rd_en, clr_busy;
  logic [IdxW-1:0]  rd_addr, next_waddr, prev_waddr, stat_waddr;

  assign reg_sel = rrq_pkg::cfg_reg_e'(paddr[2]);
  assign wr_fire = psel && penable && pwrite;

  always_comb begin
    idle_task_id_d = idle_task_id_q;
    idle_slice_d   = idle_slice_q;
    prdata         = '0;
    unique case (reg_sel)
      rrq_pkg::CfgIdleTaskId: begin
        prdata = rrq_pkg::PdataW'(idle_task_id_q);
        if (wr_fire) begin
          idle_task_id_d = pwdata[rrq_pkg::IdW-1:0];
        end
      end
      rrq_pkg::CfgIdleSlice: begin
        prdata = rrq_pkg::PdataW'(idle_slice_q);
        if (wr_fire) begin
          idle_slice_d = pwdata[rrq_pkg::SliceW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_task_id_q <= '0;
      idle_slice_q   <= rrq_pkg::IdleSliceReset;
    end else begin
      idle_task_id_q <= idle_task_id_d;
      idle_slice_q   <= idle_slice_d;
    end
  end

  assign pready = 1'b1;

  rrq_ctrl #(
    .NUM_TASKS (NUM_TASKS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o),
    .idle_task_id_i (idle_task_id_q),
    .idle_slice_i   (idle_slice_q),
    .clr_busy_i     (clr_busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_o           (wr),
    .next_waddr_o   (next_waddr),
    .prev_waddr_o   (prev_waddr),
    .stat_waddr_o   (stat_waddr)
  );

  rrq_store #(
    .NUM_TASKS (NUM_TASKS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data),
    .wr_i         (wr),
    .next_waddr_i (next_waddr),
    .prev_waddr_i (prev_waddr),
    .stat_waddr_i (stat_waddr),
    .clr_busy_o   (clr_busy)
  );

endmodule
